[design/spq_pkg.sv]
// shared codes, state encoding and control types for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

  // operation codes on the request channel
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

[design/spq_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface spq_in_if #(
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [KEY_BITS-1:0]     priority_key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, mode, priority_key, payload, input ready);
  modport sink   (input valid, mode, priority_key, payload, output ready);
endinterface

interface spq_out_if #(
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    now_empty;
  logic [COUNT_BITS-1:0]   occupancy;

  modport source (output valid, status, out_key, out_payload, now_empty, occupancy,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, now_empty, occupancy,
                  output ready);
endinterface

[design/spq_ctrl.sv]
// controller: sequences capture and execute and owns the response valid flag
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state, state_next;
  logic            rsp_valid_next;
  logic            go;

  // the response register is free or being drained this cycle
  assign go = !rsp_valid || rsp_ready;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      spq_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        if (go) begin
          cmd.execute = 1'b1;
          state_next  = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.execute) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  assign req_ready = (state == spq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[design/spq_dp.sv]
// datapath: sorted row of entry cells, occupancy count and result register
`timescale 1ns / 1ps
module spq_dp #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  spq_pkg::cmd_t           cmd,
  input  logic [1:0]              mode,
  input  logic [KEY_BITS-1:0]     priority_key,
  input  logic [PAYLOAD_BITS-1:0] payload,
  output logic [1:0]              status,
  output logic [KEY_BITS-1:0]     out_key,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    now_empty,
  output logic [COUNT_BITS-1:0]   occupancy
);

  logic [1:0]              op_mode;
  logic [KEY_BITS-1:0]     op_key;
  logic [PAYLOAD_BITS-1:0] op_pay;

  logic [KEY_BITS-1:0]     keys [DEPTH];
  logic [PAYLOAD_BITS-1:0] pays [DEPTH];
  logic [COUNT_BITS-1:0]   count, count_next;

  logic [DEPTH-1:0] lt;
  logic             full, empty;
  logic             do_ins, do_rem;
  logic [1:0]       status_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode <= mode;
      op_key  <= priority_key;
      op_pay  <= payload;
    end
  end

  // each live cell holding a smaller key stays put; the rest make room
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (COUNT_BITS'(i) < count) && (keys[i] < op_key);
    end
  end

  assign full  = (count == COUNT_BITS'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    status_next = spq_pkg::STATUS_DONE;
    count_next  = count;
    case (op_mode)
      spq_pkg::MODE_INSERT: begin
        if (full) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          do_ins     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      spq_pkg::MODE_REMOVE: begin
        if (empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          do_rem     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      spq_pkg::MODE_CLEAR: begin
        if (empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          count_next = '0;
        end
      end
      default: begin
        status_next = spq_pkg::STATUS_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic take_new, take_prev;
    if (g == 0) begin : g_first
      assign take_new  = !lt[g];
      assign take_prev = 1'b0;
    end else begin : g_rest
      assign take_new  = !lt[g] && lt[g-1];
      assign take_prev = !lt[g] && !lt[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.execute) begin
        if (do_ins) begin
          if (take_new) begin
            keys[g] <= op_key;
            pays[g] <= op_pay;
          end else if (take_prev) begin
            keys[g] <= keys[(g == 0) ? 0 : g - 1];
            pays[g] <= pays[(g == 0) ? 0 : g - 1];
          end
        end else if (do_rem && (g < DEPTH - 1)) begin
          keys[g] <= keys[(g < DEPTH - 1) ? g + 1 : g];
          pays[g] <= pays[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status      <= status_next;
      out_key     <= do_rem ? keys[0] : '0;
      out_payload <= do_rem ? pays[0] : '0;
      now_empty   <= (count_next == '0);
      occupancy   <= count_next;
    end
  end

endmodule

[design/sorted_priority_queue.sv]
// sorted priority queue: one request beat in, one response beat out per operation
// timing: the request is captured into the operand registers, then the result register; held while a response stalls
// sequencing: a new request is taken only after the last one has executed, set by the capture/execute controller
// around a single compare-and-shift step over the whole row of entry cells
// reset: synchronous, clears the occupancy count and the response valid flag;
// entry contents stay undefined and need no clearing pass
`timescale 1ns / 1ps
module sorted_priority_queue #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  spq_dp #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (req.mode),
    .priority_key (req.priority_key),
    .payload      (req.payload),
    .status       (rsp.status),
    .out_key      (rsp.out_key),
    .out_payload  (rsp.out_payload),
    .now_empty    (rsp.now_empty),
    .occupancy    (rsp.occupancy)
  );

endmodule

[design/spq_checker.sv]
// port-level checks for the sorted priority queue, bound to the top level
`timescale 1ns / 1ps
module spq_checker #(
  parameter int DEPTH        = 16,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int COUNT_BITS   = $clog2(DEPTH + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [1:0]              status,
  input logic [KEY_BITS-1:0]     out_key,
  input logic [PAYLOAD_BITS-1:0] out_payload,
  input logic                    now_empty,
  input logic [COUNT_BITS-1:0]   occupancy
);

  // a waiting response beat holds its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(occupancy)
      && $stable(out_key) && $stable(out_payload))
    else $error("response beat changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> occupancy <= COUNT_BITS'(DEPTH) && now_empty == (occupancy == '0))
    else $error("occupancy out of range or empty flag wrong");

  // full is only reported with every slot taken
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::STATUS_FULL |-> occupancy == COUNT_BITS'(DEPTH))
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::STATUS_EMPTY
      |-> now_empty && out_key == '0 && out_payload == '0)
    else $error("empty status with entries or removed data");

  // a taken beat carrying a removed entry with a nonzero key never shows a full queue
  a_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && status == spq_pkg::STATUS_DONE && out_key != '0
      |-> occupancy < COUNT_BITS'(DEPTH))
    else $error("removal left the queue full");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH        (DEPTH),
  .KEY_BITS     (KEY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .out_key     (rsp.out_key),
  .out_payload (rsp.out_payload),
  .now_empty   (rsp.now_empty),
  .occupancy   (rsp.occupancy)
);
